// ===== src/mwpo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_pkg: shared types, constants and functions of the oscillator
// Field widths, waveform codes, register map and the sine quarter-table math.
// ----------------------------------------------------------------------------
package mwpo_pkg;

  // Field and datapath widths.
  localparam int WAVE_W   = 3;
  localparam int FREQ_W   = 24;
  localparam int STEP_W   = 28;
  localparam int SMP_W    = 20;
  localparam int PHASE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = FREQ_W + STEP_W + 1;
  localparam int MAG_W    = 16;
  localparam int ENTRY_W  = MAG_W + 1;

  // Waveform codes.
  localparam logic [WAVE_W-1:0] WAVE_SAW     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE  = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SINE    = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_BL_SAW  = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_BL_SQR  = 3'd4;

  // Register map.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_PER_HZ = 1'd0;
  localparam logic [STEP_W-1:0]    STEP_RESET      = 28'd24932271;

  // Sample levels.
  localparam int UNIT_LEVEL = 32768;
  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;

  // Odd polynomial coefficients of the quarter sine, Q30.
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = -64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = -64'sd5026994;
  localparam longint SIN_C9 = 64'sd172272;

  // Response of the sine table: one signed entry.
  typedef struct packed {
    logic                      vld;
    logic signed [ENTRY_W-1:0] entry;
  } rom_rsp_t;

  // Signed Q30 coefficient times unsigned Q30 value, truncated toward zero.
  function automatic longint mul_q30(input longint a, input logic [63:0] b);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    p   = (mag * b) >> 30;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  // Magnitude of the quarter-wave table at position pos; only used to build
  // constant tables during elaboration.
  function automatic logic [MAG_W-1:0] sine_mag(input int pos, input int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    longint      acc;
    longint      y;
    x   = 64'(pos) << (30 - qbits);
    x2  = (x * x) >> 30;
    acc = SIN_C9;
    acc = SIN_C7 + mul_q30(acc, x2);
    acc = SIN_C5 + mul_q30(acc, x2);
    acc = SIN_C3 + mul_q30(acc, x2);
    acc = SIN_C1 + mul_q30(acc, x2);
    y   = mul_q30(acc, x);
    if (y < 0) begin
      y = 0;
    end
    return MAG_W'((64'(y) + 64'd16384) >> 15);
  endfunction

endpackage
`default_nettype wire

// ===== src/mwpo_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_ifs: item channels of the oscillator
// Valid/ready channels for the tick items and the sample items.
// ----------------------------------------------------------------------------
interface mwpo_in_if;
  import mwpo_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [WAVE_W-1:0] waveform;
  logic signed [FREQ_W-1:0] frequency;

  modport source (output valid, output waveform, output frequency, input ready);
  modport sink   (input valid, input waveform, input frequency, output ready);
endinterface

interface mwpo_out_if;
  import mwpo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== src/mwpo_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_apb_regs: configuration register file
// Holds the phase step per hertz behind an APB-style slave port.
// ----------------------------------------------------------------------------
module mwpo_apb_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwpo_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mwpo_pkg::PDATA_W-1:0] pwdata,
  output      logic [mwpo_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready,
  output      logic [mwpo_pkg::STEP_W-1:0]  step_per_hz
);
  import mwpo_pkg::*;

  logic [STEP_W-1:0]    step_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_STEP_PER_HZ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (wr_en) begin
      step_r <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_PER_HZ: prdata = PDATA_W'(step_r);
      default:         prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign step_per_hz = step_r;

endmodule
`default_nettype wire

// ===== src/mwpo_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_sine_rom: registered sine lookup
// Quarter-wave constant table with quadrant mirroring and sign, one read per
// cycle, result registered and presented in the cycle after the request.
// ----------------------------------------------------------------------------
module mwpo_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req,
  input  wire logic [ADDR_BITS-1:0] addr,
  output      mwpo_pkg::rom_rsp_t   rsp
);
  import mwpo_pkg::*;

  localparam int QBITS = ADDR_BITS - 2;
  localparam int QSIZE = 1 << QBITS;

  logic [MAG_W-1:0] quarter [QSIZE+1];
  logic [1:0]       quad;
  logic [QBITS-1:0] r;
  logic [QBITS:0]   pos;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic             vld_r;
  logic signed [ENTRY_W-1:0] entry_s;

  // The quarter table holds QSIZE+1 points, both ends included.
  for (genvar i = 0; i <= QSIZE; i++) begin : g_tab
    localparam logic [MAG_W-1:0] VAL = sine_mag(i, QBITS);
    assign quarter[i] = VAL;
  end

  assign quad = addr[ADDR_BITS-1 -: 2];
  assign r    = addr[QBITS-1:0];
  assign pos  = quad[0] ? ((QBITS+1)'(QSIZE) - {1'b0, r}) : {1'b0, r};

  always_ff @(posedge clk) begin
    if (req) begin
      mag_r <= quarter[pos];
      neg_r <= quad[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req;
    end
  end

  assign entry_s = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign rsp     = '{vld: vld_r, entry: entry_s};

endmodule
`default_nettype wire

// ===== src/multi_waveform_phase_oscillator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_top: multi-waveform phase oscillator
// NCO with saw, square, sine and additive band-limited saw and square.
// ----------------------------------------------------------------------------
// Each input item is one sample tick. It advances a 32-bit phase accumulator
// by floor(frequency * step_per_hz / 2^16), wrapping modulo 2^32, and yields
// one signed Q4.15 sample of the selected waveform. Saw and square go from
// the idle state through the phase update to the finish state; sine (one
// lookup) and the band-limited saw and square (HARMONICS lookups) also pass
// through harmonic summation, where the single sine table port serves one
// harmonic per cycle: harmonic phases are stepped by repeated addition of
// the base phase (or twice it for the odd-harmonic square), and each table
// result is added into one signed accumulator. Unused waveform codes advance
// the phase and give a zero sample. Sums are saturated to the 20-bit sample
// range. A finished sample waits in the output register, so the next item
// may be accepted while it is still held; it is only overwritten after it
// has been taken. The step_per_hz register sits at byte address 0; the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_top #(
  parameter int HARMONICS      = 11,
  parameter int SINE_ADDR_BITS = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  mwpo_in_if.sink                           in_ch,
  mwpo_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwpo_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mwpo_pkg::PDATA_W-1:0] pwdata,
  output      logic [mwpo_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready
);
  import mwpo_pkg::*;

  // The accumulator must hold HARMONICS full-scale entries.
  localparam int SUM_W = ENTRY_W + $clog2(HARMONICS);
  localparam int SAT_W = (SUM_W > SMP_W + 1) ? SUM_W : SMP_W + 1;
  localparam int CNT_W = $clog2(HARMONICS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_HARM = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                    state_r,      state_nxt;
  logic        [WAVE_W-1:0]  wave_r,       wave_nxt;
  logic        [PHASE_W-1:0] inc_r,        inc_nxt;
  logic        [PHASE_W-1:0] phase_acc_r,  phase_acc_nxt;
  logic        [PHASE_W-1:0] hphase_r,     hphase_nxt;
  logic        [PHASE_W-1:0] hstep_r,      hstep_nxt;
  logic        [CNT_W-1:0]   cnt_r,        cnt_nxt;
  logic signed [SUM_W-1:0]   sum_r,        sum_nxt;
  logic                      out_valid_r,  out_valid_nxt;
  logic signed [SMP_W-1:0]   sample_r,     sample_nxt;

  logic [STEP_W-1:0]         step_per_hz;
  logic signed [PROD_W-1:0]  prod;
  logic                      in_acc;
  logic                      rom_req;
  rom_rsp_t                  rom_rsp;
  logic signed [SAT_W-1:0]   sum_ext;
  logic signed [SMP_W-1:0]   sum_sat;

  mwpo_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .step_per_hz (step_per_hz)
  );

  // The shared lookup unit: one harmonic is issued per cycle while the
  // harmonic counter is nonzero, its entry returns in the following cycle.
  assign rom_req = (state_r == S_HARM) && (cnt_r != '0);

  mwpo_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rom_req),
    .addr  (hphase_r[PHASE_W-1 -: SINE_ADDR_BITS]),
    .rsp   (rom_rsp)
  );

  // Frequency times step is a 24 by 29 bit signed product; its bits above
  // the 16 fraction bits, taken modulo 2^32, are the phase increment.
  assign prod     = in_ch.frequency * $signed({1'b0, step_per_hz});
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;

  // Saturate the accumulated sum to the sample range.
  assign sum_ext = SAT_W'(sum_r);
  always_comb begin
    if (sum_ext > SAT_W'(SAMPLE_MAX)) begin
      sum_sat = SMP_W'(SAMPLE_MAX);
    end else if (sum_ext < SAT_W'(SAMPLE_MIN)) begin
      sum_sat = SMP_W'(SAMPLE_MIN);
    end else begin
      sum_sat = SMP_W'(sum_ext);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wave_nxt      = wave_r;
    inc_nxt       = inc_r;
    phase_acc_nxt = phase_acc_r;
    hphase_nxt    = hphase_r;
    hstep_nxt     = hstep_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wave_nxt  = in_ch.waveform;
          inc_nxt   = prod[FRAC_W +: PHASE_W];
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        phase_acc_nxt = phase_acc_r + inc_r;
        hphase_nxt    = phase_acc_nxt;
        // Odd harmonics step by twice the base phase.
        hstep_nxt     = (wave_r == WAVE_BL_SQR) ? {phase_acc_nxt[PHASE_W-2:0], 1'b0}
                                                : phase_acc_nxt;
        sum_nxt       = '0;
        cnt_nxt       = '0;
        state_nxt     = S_FIN;
        case (wave_r) inside
          WAVE_SAW: begin
            sum_nxt = SUM_W'($signed({1'b0, phase_acc_nxt[PHASE_W-1 -: 16]}) -
                             $signed(17'(UNIT_LEVEL)));
          end
          WAVE_SQUARE: begin
            sum_nxt = phase_acc_nxt[PHASE_W-1] ? -SUM_W'(UNIT_LEVEL) : SUM_W'(UNIT_LEVEL);
          end
          WAVE_SINE: begin
            cnt_nxt   = CNT_W'(1);
            state_nxt = S_HARM;
          end
          WAVE_BL_SAW, WAVE_BL_SQR: begin
            cnt_nxt   = CNT_W'(HARMONICS);
            state_nxt = S_HARM;
          end
          default: begin
            sum_nxt = '0;
          end
        endcase
      end

      S_HARM: begin
        if (cnt_r != '0) begin
          hphase_nxt = hphase_r + hstep_r;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end
        if (rom_rsp.vld) begin
          sum_nxt = sum_r + SUM_W'(rom_rsp.entry);
        end
        if ((cnt_r == '0) && !rom_rsp.vld) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // The previous sample must be gone before this one replaces it.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          sample_nxt    = sum_sat;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_acc_r <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wave_r   <= wave_nxt;
    inc_r    <= inc_nxt;
    hphase_r <= hphase_nxt;
    hstep_r  <= hstep_nxt;
    sum_r    <= sum_nxt;
    sample_r <= sample_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;

  // An accepted item always moves on to the phase update.
  a_accept_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ADD))
    else $error("accepted item did not enter phase update");

  // The harmonic counter never exceeds the number of harmonics.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HARMONICS))
    else $error("harmonic counter out of range");

  // Table results only come back while harmonics are being summed.
  a_rom_in_harm: assert property (@(posedge clk) disable iff (!rst_n)
    rom_rsp.vld |-> (state_r == S_HARM))
    else $error("sine table result outside harmonic summation");

  // A new sample is only presented after an item finished.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("sample presented without a finished item");

  // Summation is left only once all issued lookups have been added.
  a_harm_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_HARM) && (state_nxt == S_FIN)) |-> (cnt_r == '0) && !rom_rsp.vld)
    else $error("harmonic summation left early");

endmodule
`default_nettype wire
